>>> hdl/u8d_pkg.sv
package u8d_pkg;

   // byte class boundaries
   localparam logic [7:0] ASCII_LIMIT    = 8'h80;
   localparam logic [7:0] LEAD2_START    = 8'hC0;
   localparam logic [7:0] LEAD3_START    = 8'hE0;
   localparam logic [7:0] LEAD4_START    = 8'hF0;

   // payload masks for lead and continuation bytes
   localparam logic [7:0] LEAD2_MASK     = 8'h1F;
   localparam logic [7:0] LEAD3_MASK     = 8'h0F;
   localparam logic [7:0] LEAD4_MASK     = 8'h07;
   localparam logic [7:0] CONT_MASK      = 8'h3F;

   localparam int         CP_WIDTH       = 21;
   localparam logic [CP_WIDTH-1:0] QMARK_CP    = 21'h00003F;
   localparam logic [CP_WIDTH-1:0] LATIN1_TOP  = 21'h000100;

   // continuation bytes still expected after a lead
   localparam logic [1:0] PEND_LEAD2     = 2'd1;
   localparam logic [1:0] PEND_LEAD3     = 2'd2;
   localparam logic [1:0] PEND_LEAD4     = 2'd3;
   localparam logic [1:0] PEND_NONE      = 2'd0;

   // one result beat
   typedef struct packed {
      logic [CP_WIDTH-1:0] codepoint;
      logic                above_latin1;
      logic                malformed;
      logic                last_of_run;
   } res_type;

endpackage

>>> hdl/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder: takes one byte per cycle when not stalled and returns one
// codepoint beat per completed sequence (or a '?' beat for a stray continuation byte or
// a sequence cut off by run_end), registered in the result register or the skid entry.
// Throughput is one byte every cycle while req_stall is low; the decode is a single pass
// of logic from the accepted byte and sequence state into these two output entries, which
// keep the input moving while a result waits; req_stall rises only when both are full.
module utf8_byte_stream_decoder
   import u8d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_run_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CP_WIDTH-1:0] rsp_codepoint,
   output logic                rsp_above_latin1,
   output logic                rsp_malformed,
   output logic                rsp_last_of_run
);

   // sequence state
   logic [1:0]          bytes_pending_ff, bytes_pending_in;
   logic [CP_WIDTH-1:0] accumulator_ff, accumulator_in;

   // output stage
   res_type out_ff, out_in;
   res_type skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic    accept;
   logic    pop;
   logic    has_res;
   res_type res;
   logic [1:0]          pend_dec;
   logic [CP_WIDTH-1:0] acc_shift;
   logic [CP_WIDTH-1:0] res_cp;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;

   assign rsp_codepoint    = out_ff.codepoint;
   assign rsp_above_latin1 = out_ff.above_latin1;
   assign rsp_malformed    = out_ff.malformed;
   assign rsp_last_of_run  = out_ff.last_of_run;

   assign pend_dec  = bytes_pending_ff - 2'd1;
   assign acc_shift = {accumulator_ff[CP_WIDTH-7:0], req_data_byte[5:0] & CONT_MASK[5:0]};

   // decode of the accepted byte
   always_comb begin
      bytes_pending_in = bytes_pending_ff;
      accumulator_in   = accumulator_ff;
      has_res          = 1'b0;
      res_cp           = QMARK_CP;
      res.malformed    = 1'b0;
      if (bytes_pending_ff != PEND_NONE) begin
         accumulator_in   = acc_shift;
         bytes_pending_in = pend_dec;
         if (pend_dec == PEND_NONE) begin
            has_res        = 1'b1;
            res_cp         = acc_shift;
            accumulator_in = '0;
         end else if (req_run_end) begin
            has_res          = 1'b1;
            res.malformed    = 1'b1;
            bytes_pending_in = PEND_NONE;
            accumulator_in   = '0;
         end
      end else if (req_data_byte < ASCII_LIMIT) begin
         has_res = 1'b1;
         res_cp  = {{(CP_WIDTH-8){1'b0}}, req_data_byte};
      end else if (req_data_byte < LEAD2_START) begin
         // stray continuation
         has_res       = 1'b1;
         res.malformed = 1'b1;
      end else begin
         if (req_data_byte < LEAD3_START) begin
            accumulator_in   = {{(CP_WIDTH-8){1'b0}}, req_data_byte & LEAD2_MASK};
            bytes_pending_in = PEND_LEAD2;
         end else if (req_data_byte < LEAD4_START) begin
            accumulator_in   = {{(CP_WIDTH-8){1'b0}}, req_data_byte & LEAD3_MASK};
            bytes_pending_in = PEND_LEAD3;
         end else begin
            accumulator_in   = {{(CP_WIDTH-8){1'b0}}, req_data_byte & LEAD4_MASK};
            bytes_pending_in = PEND_LEAD4;
         end
         // lead on the run's last byte is a cut sequence
         if (req_run_end) begin
            has_res          = 1'b1;
            res.malformed    = 1'b1;
            bytes_pending_in = PEND_NONE;
            accumulator_in   = '0;
         end
      end
      res.codepoint    = res_cp;
      res.above_latin1 = (res_cp >= LATIN1_TOP);
      res.last_of_run  = req_run_end;
   end

   // output stage next state
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && has_res) begin
         if (out_valid_ff && !pop) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = res;
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff <= PEND_NONE;
         accumulator_ff   <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            bytes_pending_ff <= bytes_pending_in;
            accumulator_ff   <= accumulator_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   // skid entry only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty result register");

   // substituted results always carry '?'
   a_malformed_qmark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_malformed) |-> (rsp_codepoint == QMARK_CP && !rsp_above_latin1))
      else $error("malformed beat without question mark");

   // a run end always closes the open sequence
   a_run_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_run_end) |=> (bytes_pending_ff == PEND_NONE && accumulator_ff == '0))
      else $error("sequence state survived run end");

   // a stalled result does not change
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result changed");
`endif

endmodule
